// ===== src/tss_pkg.sv =====
// shared types and constants of the track segment summary unit
`default_nettype none

package tss_pkg;

    // segment limits and geometry constants
    localparam int MAX_HITS      = 64;
    localparam int TSS_CNT_W     = 7;
    localparam int TSS_WIRE_W    = 10;
    localparam int TSS_POS_W     = 16;
    localparam int TSS_CONF_W    = 24;
    localparam int TSS_DIR_W     = 25;
    localparam int TSS_SUM_W     = 22;
    localparam int TSS_R2_W      = 32;
    localparam int TSS_MEAN_W    = 16;
    localparam logic [TSS_WIRE_W-1:0] TSS_WIRE_INIT = TSS_WIRE_W'(1000);

    // serial shift-subtract unit sizing
    localparam int TSS_OPND_W    = 32;
    localparam int TSS_RES_W     = 22;
    localparam int TSS_REM_W     = 20;
    localparam int TSS_STEP_W    = 5;
    localparam int TSS_SQRT_STEPS = TSS_OPND_W / 2;
    localparam int TSS_DIV_STEPS  = TSS_SUM_W;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_UPDATE,
        ST_ROOT,
        ST_DIV_R_GO,
        ST_DIV_R,
        ST_DIV_Z_GO,
        ST_DIV_Z,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== src/track_segment_summary_unit.sv =====
// top level of the drift-chamber track segment summary unit
//
// Input channel (i_valid / o_ready) takes one wire hit per transfer; the hit
// marked by i_last_hit closes the segment. Output channel (o_valid / i_ready)
// carries one summary per segment: conformal direction, folded wire span,
// mean radius and mean z, hit count and an overflow flag.
// Each hit is worked on alone: squaring of x and then of y on one 16x16
// multiplier, an update state, then a start strobe, 16 steps of a bit-serial
// square root and a done pulse in the shared shift-subtract unit, after which
// o_ready rises again.
// A closing hit adds two 22-step divisions in the same unit (radius sum and
// z sum by the hit count), each with its own start state and done pulse, and
// then the final state, which loads the summary into the output register.
// Hits beyond MAX_HITS skip all arithmetic and only set the overflow flag.
// The summary sits in an output register; the next segment's hits are taken
// while it waits. If the receiver stalls and a second summary is ready, the
// unit holds in its final state, with o_ready low, until the slot frees.
// Synchronous reset clears the segment state and the output valid.
`default_nettype none

module track_segment_summary_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic signed [tss_pkg::TSS_POS_W-1:0]   i_wire_x,
    input  wire logic signed [tss_pkg::TSS_POS_W-1:0]   i_wire_y,
    input  wire logic signed [tss_pkg::TSS_POS_W-1:0]   i_wire_z,
    input  wire logic signed [tss_pkg::TSS_CONF_W-1:0]  i_conf_x,
    input  wire logic signed [tss_pkg::TSS_CONF_W-1:0]  i_conf_y,
    input  wire logic        [tss_pkg::TSS_WIRE_W-1:0]  i_wire_number,
    input  wire logic        [tss_pkg::TSS_WIRE_W-1:0]  i_layer_wires,
    input  wire logic                                   i_last_hit,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic signed      [tss_pkg::TSS_DIR_W-1:0]   o_dir_x,
    output logic signed      [tss_pkg::TSS_DIR_W-1:0]   o_dir_y,
    output logic             [tss_pkg::TSS_WIRE_W-1:0]  o_wire_span,
    output logic             [tss_pkg::TSS_MEAN_W-1:0]  o_mean_radius,
    output logic signed      [tss_pkg::TSS_MEAN_W-1:0]  o_mean_z,
    output logic             [tss_pkg::TSS_CNT_W-1:0]   o_hits_used,
    output logic                                        o_overflow
);
    import tss_pkg::*;

    t_state r_state;
    t_state n_state;

    // latched hit
    logic signed [TSS_POS_W-1:0]  r_x;
    logic signed [TSS_POS_W-1:0]  r_y;
    logic signed [TSS_POS_W-1:0]  r_z;
    logic signed [TSS_CONF_W-1:0] r_cx;
    logic signed [TSS_CONF_W-1:0] r_cy;
    logic [TSS_WIRE_W-1:0]        r_wire;
    logic [TSS_WIRE_W-1:0]        r_lsize;
    logic                         r_last;
    logic [TSS_R2_W-1:0]          r_r2;

    // segment state
    logic [TSS_CNT_W-1:0]         r_hit_count;
    logic                         r_count_ovf;
    logic [TSS_R2_W-1:0]          r_min_r2;
    logic [TSS_R2_W-1:0]          r_max_r2;
    logic signed [TSS_CONF_W-1:0] r_inner_cx;
    logic signed [TSS_CONF_W-1:0] r_inner_cy;
    logic signed [TSS_CONF_W-1:0] r_outer_cx;
    logic signed [TSS_CONF_W-1:0] r_outer_cy;
    logic [TSS_WIRE_W-1:0]        r_least_wire;
    logic [TSS_WIRE_W-1:0]        r_greatest_wire;
    logic [TSS_WIRE_W-1:0]        r_least_lsize;
    logic [TSS_SUM_W-1:0]         r_radius_sum;
    logic signed [TSS_SUM_W-1:0]  r_z_sum;
    logic [TSS_MEAN_W-1:0]        r_mean_r;
    logic signed [TSS_MEAN_W-1:0] r_mean_z;

    // output register
    logic                         r_o_valid;
    logic signed [TSS_DIR_W-1:0]  r_o_dir_x;
    logic signed [TSS_DIR_W-1:0]  r_o_dir_y;
    logic [TSS_WIRE_W-1:0]        r_o_span;
    logic [TSS_MEAN_W-1:0]        r_o_mean_r;
    logic signed [TSS_MEAN_W-1:0] r_o_mean_z;
    logic [TSS_CNT_W-1:0]         r_o_hits;
    logic                         r_o_ovf;

    // control and shared datapath signals
    logic                         w_in_xfer;
    logic                         w_full;
    logic                         w_fin_load;
    t_unit_ctl                    w_ctl;
    logic [TSS_OPND_W-1:0]        w_operand;
    logic [TSS_CNT_W-1:0]         w_divisor;
    logic [TSS_RES_W-1:0]         w_result;
    logic                         w_done;
    logic signed [TSS_POS_W-1:0]  w_mul_a;
    logic signed [TSS_R2_W-1:0]   w_prod;
    logic                         w_z_neg;
    logic [TSS_SUM_W-1:0]         w_z_abs;
    logic [TSS_RES_W-1:0]         w_z_q;
    logic [TSS_WIRE_W-1:0]        w_span_raw;
    logic [TSS_WIRE_W-1:0]        w_span;

    assign w_full    = (r_hit_count >= TSS_CNT_W'(MAX_HITS));
    assign w_in_xfer = i_valid && o_ready;

    // shared shift-subtract unit
    tss_serial_unit u_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_operand (w_operand),
        .i_divisor (w_divisor),
        .o_result  (w_result),
        .o_done    (w_done)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (!w_full) begin
                        n_state = ST_SQ_X;
                    end else if (i_last_hit) begin
                        n_state = ST_DIV_R_GO;
                    end
                end
            end
            ST_SQ_X:     n_state = ST_SQ_Y;
            ST_SQ_Y:     n_state = ST_UPDATE;
            ST_UPDATE:   n_state = ST_ROOT;
            ST_ROOT: begin
                if (w_done) begin
                    n_state = r_last ? ST_DIV_R_GO : ST_IDLE;
                end
            end
            ST_DIV_R_GO: n_state = ST_DIV_R;
            ST_DIV_R: begin
                if (w_done) begin
                    n_state = ST_DIV_Z_GO;
                end
            end
            ST_DIV_Z_GO: n_state = ST_DIV_Z;
            ST_DIV_Z: begin
                if (w_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_o_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready    = (r_state == ST_IDLE);
        w_fin_load = (r_state == ST_FINISH) && (!r_o_valid || i_ready);
        w_ctl.start = (r_state == ST_UPDATE) || (r_state == ST_DIV_R_GO)
                   || (r_state == ST_DIV_Z_GO);
        w_ctl.op    = (r_state == ST_UPDATE) ? OP_SQRT : OP_DIV;
        w_mul_a     = (r_state == ST_SQ_X) ? r_x : r_y;
    end

    // unit operands
    assign w_z_neg   = r_z_sum[TSS_SUM_W-1];
    assign w_z_abs   = w_z_neg ? TSS_SUM_W'(-r_z_sum) : TSS_SUM_W'(r_z_sum);
    assign w_divisor = (r_hit_count == '0) ? TSS_CNT_W'(1) : r_hit_count;
    always_comb begin
        unique case (r_state)
            ST_DIV_R_GO: w_operand = {r_radius_sum, (TSS_OPND_W-TSS_SUM_W)'(0)};
            ST_DIV_Z_GO: w_operand = {w_z_abs, (TSS_OPND_W-TSS_SUM_W)'(0)};
            default:     w_operand = r_r2;
        endcase
    end

    // squaring on the single multiplier
    assign w_prod = w_mul_a * w_mul_a;

    // mean z restored to its sign
    assign w_z_q = w_z_neg ? (TSS_RES_W'(0) - w_result) : w_result;

    // wire span folded across zero
    always_comb begin
        if (r_greatest_wire >= r_least_wire) begin
            w_span_raw = r_greatest_wire - r_least_wire;
        end else begin
            w_span_raw = r_least_wire - r_greatest_wire;
        end
        w_span = w_span_raw;
        if (w_span_raw > (r_least_lsize >> 1)) begin
            w_span = (r_least_lsize >= w_span_raw) ? (r_least_lsize - w_span_raw)
                                                   : '0;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hit latch and squared radius
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_x     <= i_wire_x;
            r_y     <= i_wire_y;
            r_z     <= i_wire_z;
            r_cx    <= i_conf_x;
            r_cy    <= i_conf_y;
            r_wire  <= i_wire_number;
            r_lsize <= i_layer_wires;
            r_last  <= i_last_hit;
        end
        if (r_state == ST_SQ_X) begin
            r_r2 <= TSS_R2_W'(w_prod);
        end else if (r_state == ST_SQ_Y) begin
            r_r2 <= r_r2 + TSS_R2_W'(w_prod);
        end
    end

    // innermost and outermost hit by squared radius, and the two means
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            if (r_hit_count == '0) begin
                r_min_r2   <= r_r2;
                r_max_r2   <= r_r2;
                r_inner_cx <= r_cx;
                r_inner_cy <= r_cy;
                r_outer_cx <= r_cx;
                r_outer_cy <= r_cy;
            end else begin
                if (r_r2 < r_min_r2) begin
                    r_min_r2   <= r_r2;
                    r_inner_cx <= r_cx;
                    r_inner_cy <= r_cy;
                end
                if (r_r2 > r_max_r2) begin
                    r_max_r2   <= r_r2;
                    r_outer_cx <= r_cx;
                    r_outer_cy <= r_cy;
                end
            end
        end
        if ((r_state == ST_DIV_R) && w_done) begin
            r_mean_r <= w_result[TSS_MEAN_W-1:0];
        end
        if ((r_state == ST_DIV_Z) && w_done) begin
            r_mean_z <= w_z_q[TSS_MEAN_W-1:0];
        end
    end

    // segment counters, wire extremes and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_fin_load) begin
            r_hit_count     <= '0;
            r_count_ovf     <= 1'b0;
            r_least_wire    <= TSS_WIRE_INIT;
            r_greatest_wire <= '0;
            r_least_lsize   <= '0;
            r_radius_sum    <= '0;
            r_z_sum         <= '0;
        end else begin
            if (w_in_xfer && w_full) begin
                r_count_ovf <= 1'b1;
            end
            if (r_state == ST_UPDATE) begin
                if (r_wire < r_least_wire) begin
                    r_least_wire  <= r_wire;
                    r_least_lsize <= r_lsize;
                end
                if (r_wire > r_greatest_wire) begin
                    r_greatest_wire <= r_wire;
                end
                r_z_sum <= r_z_sum + TSS_SUM_W'(r_z);
            end
            if ((r_state == ST_ROOT) && w_done) begin
                r_radius_sum <= r_radius_sum + TSS_SUM_W'(w_result);
                r_hit_count  <= r_hit_count + TSS_CNT_W'(1);
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_fin_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_o_dir_x  <= TSS_DIR_W'(r_inner_cx) - TSS_DIR_W'(r_outer_cx);
            r_o_dir_y  <= TSS_DIR_W'(r_inner_cy) - TSS_DIR_W'(r_outer_cy);
            r_o_span   <= w_span;
            r_o_mean_r <= r_mean_r;
            r_o_mean_z <= r_mean_z;
            r_o_hits   <= r_hit_count;
            r_o_ovf    <= r_count_ovf;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_dir_x       = r_o_dir_x;
    assign o_dir_y       = r_o_dir_y;
    assign o_wire_span   = r_o_span;
    assign o_mean_radius = r_o_mean_r;
    assign o_mean_z      = r_o_mean_z;
    assign o_hits_used   = r_o_hits;
    assign o_overflow    = r_o_ovf;

endmodule

`default_nettype wire

// ===== src/tss_serial_unit.sv =====
// bit-serial shift-subtract unit: integer square root or unsigned division
`default_nettype none

module tss_serial_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tss_pkg::t_unit_ctl                i_ctl,
    input  wire logic [tss_pkg::TSS_OPND_W-1:0]    i_operand,
    input  wire logic [tss_pkg::TSS_CNT_W-1:0]     i_divisor,
    output logic      [tss_pkg::TSS_RES_W-1:0]     o_result,
    output logic                                   o_done
);
    import tss_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    t_op                   r_op;
    logic [TSS_STEP_W-1:0] r_step;
    logic [TSS_OPND_W-1:0] r_src;
    logic [TSS_REM_W-1:0]  r_rem;
    logic [TSS_RES_W-1:0]  r_res;
    logic [TSS_CNT_W-1:0]  r_divisor;

    logic [TSS_REM_W-1:0]  w_rem_sh;
    logic [TSS_REM_W-1:0]  w_trial;
    logic [TSS_REM_W:0]    w_diff;
    logic                  w_ge;
    logic                  w_last;

    // one step: bring in the next operand bits, trial subtract
    always_comb begin
        unique case (r_op)
            OP_SQRT: begin
                w_rem_sh = {r_rem[TSS_REM_W-3:0], r_src[TSS_OPND_W-1 -: 2]};
                w_trial  = {r_res[TSS_REM_W-3:0], 2'b01};
                w_last   = (r_step == TSS_STEP_W'(TSS_SQRT_STEPS - 1));
            end
            OP_DIV: begin
                w_rem_sh = {r_rem[TSS_REM_W-2:0], r_src[TSS_OPND_W-1]};
                w_trial  = TSS_REM_W'(r_divisor);
                w_last   = (r_step == TSS_STEP_W'(TSS_DIV_STEPS - 1));
            end
            default: begin
                w_rem_sh = '0;
                w_trial  = '0;
                w_last   = 1'b1;
            end
        endcase
        w_diff = {1'b0, w_rem_sh} - {1'b0, w_trial};
        w_ge   = ~w_diff[TSS_REM_W];
    end

    // control: busy while stepping, done pulses after the final step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op      <= i_ctl.op;
            r_src     <= i_operand;
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_res     <= '0;
            r_step    <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[TSS_REM_W-1:0] : w_rem_sh;
            r_res  <= {r_res[TSS_RES_W-2:0], w_ge};
            r_step <= r_step + TSS_STEP_W'(1);
            if (r_op == OP_SQRT) begin
                r_src <= {r_src[TSS_OPND_W-3:0], 2'b00};
            end else begin
                r_src <= {r_src[TSS_OPND_W-2:0], 1'b0};
            end
        end
    end

    assign o_result = r_res;
    assign o_done   = r_done;

endmodule

`default_nettype wire

// ===== test/tss_summary_checker.sv =====
// checker of the track segment summary unit: predicts every segment summary and compares it
module tss_summary_checker (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // hit channel
    input  wire logic                                   i_hit_valid,
    input  wire logic                                   i_hit_ready,
    input  wire logic signed [tss_pkg::TSS_POS_W-1:0]   i_wire_x,
    input  wire logic signed [tss_pkg::TSS_POS_W-1:0]   i_wire_y,
    input  wire logic signed [tss_pkg::TSS_POS_W-1:0]   i_wire_z,
    input  wire logic signed [tss_pkg::TSS_CONF_W-1:0]  i_conf_x,
    input  wire logic signed [tss_pkg::TSS_CONF_W-1:0]  i_conf_y,
    input  wire logic        [tss_pkg::TSS_WIRE_W-1:0]  i_wire_number,
    input  wire logic        [tss_pkg::TSS_WIRE_W-1:0]  i_layer_wires,
    input  wire logic                                   i_last_hit,
    // summary channel
    input  wire logic                                   i_sum_valid,
    input  wire logic                                   i_sum_ready,
    input  wire logic signed [tss_pkg::TSS_DIR_W-1:0]   i_dir_x,
    input  wire logic signed [tss_pkg::TSS_DIR_W-1:0]   i_dir_y,
    input  wire logic        [tss_pkg::TSS_WIRE_W-1:0]  i_wire_span,
    input  wire logic        [tss_pkg::TSS_MEAN_W-1:0]  i_mean_radius,
    input  wire logic signed [tss_pkg::TSS_MEAN_W-1:0]  i_mean_z,
    input  wire logic        [tss_pkg::TSS_CNT_W-1:0]   i_hits_used,
    input  wire logic                                   i_overflow,
    output int                                          o_mismatches,
    output int                                          o_summaries_due
);
    import tss_pkg::*;

    typedef struct packed {
        logic signed [TSS_DIR_W-1:0]  dir_x;
        logic signed [TSS_DIR_W-1:0]  dir_y;
        logic        [TSS_WIRE_W-1:0] span;
        logic        [TSS_MEAN_W-1:0] mean_radius;
        logic signed [TSS_MEAN_W-1:0] mean_z;
        logic        [TSS_CNT_W-1:0]  hits;
        logic                         overflow;
    } t_seg_summary;

    // summaries predicted but not yet seen on the output
    t_seg_summary summaries_due[$];

    // running state of the open segment
    int unsigned                  seg_hits;
    logic        [TSS_R2_W-1:0]   r2_least;
    logic        [TSS_R2_W-1:0]   r2_most;
    logic signed [TSS_CONF_W-1:0] inner_cx;
    logic signed [TSS_CONF_W-1:0] inner_cy;
    logic signed [TSS_CONF_W-1:0] outer_cx;
    logic signed [TSS_CONF_W-1:0] outer_cy;
    logic        [TSS_WIRE_W-1:0] low_wire;
    logic        [TSS_WIRE_W-1:0] high_wire;
    logic        [TSS_WIRE_W-1:0] low_wire_layer;
    logic        [TSS_SUM_W-1:0]  radius_sum;
    logic signed [TSS_SUM_W-1:0]  z_sum;
    logic                         seg_overflow;

    int mismatch_count = 0;
    int due_count      = 0;

    assign o_mismatches    = mismatch_count;
    assign o_summaries_due = due_count;

    // truncated square root, built up one result bit at a time
    function automatic logic [15:0] radius_floor(input logic [TSS_R2_W-1:0] r2);
        logic [15:0] root;
        logic [15:0] trial;
        logic [31:0] square;
        root = '0;
        for (int b = 15; b >= 0; b--) begin
            trial  = root | (16'd1 << b);
            square = 32'(trial) * 32'(trial);
            if (square <= r2) root = trial;
        end
        return root;
    endfunction

    task automatic clear_segment();
        seg_hits       = 0;
        r2_least       = '0;
        r2_most        = '0;
        inner_cx       = '0;
        inner_cy       = '0;
        outer_cx       = '0;
        outer_cy       = '0;
        low_wire       = TSS_WIRE_INIT;
        high_wire      = '0;
        low_wire_layer = '0;
        radius_sum     = '0;
        z_sum          = '0;
        seg_overflow   = 1'b0;
    endtask

    // summary of the open segment
    function automatic t_seg_summary close_segment();
        t_seg_summary s;
        int unsigned  hi;
        int unsigned  lo;
        int unsigned  lay;
        int unsigned  span;
        int unsigned  n;
        int           zq;
        hi  = 32'(high_wire);
        lo  = 32'(low_wire);
        lay = 32'(low_wire_layer);
        n   = (seg_hits == 0) ? 1 : seg_hits;
        span = (hi >= lo) ? hi - lo : lo - hi;
        // fold across zero, saturating when the span exceeds the layer
        if (span > lay / 2) span = (lay >= span) ? lay - span : 0;
        zq = int'(z_sum) / int'(n);
        s.dir_x       = TSS_DIR_W'(inner_cx) - TSS_DIR_W'(outer_cx);
        s.dir_y       = TSS_DIR_W'(inner_cy) - TSS_DIR_W'(outer_cy);
        s.span        = TSS_WIRE_W'(span);
        s.mean_radius = TSS_MEAN_W'(32'(radius_sum) / n);
        s.mean_z      = TSS_MEAN_W'(zq);
        s.hits        = TSS_CNT_W'(seg_hits);
        s.overflow    = seg_overflow;
        return s;
    endfunction

    // fold one accepted hit into the segment state
    task automatic fold_hit();
        int                   xs;
        int                   ys;
        logic [TSS_R2_W-1:0]  r2;
        xs = int'(i_wire_x);
        ys = int'(i_wire_y);
        if (seg_hits >= MAX_HITS) begin
            seg_overflow = 1'b1;
        end else begin
            r2 = TSS_R2_W'(xs * xs) + TSS_R2_W'(ys * ys);
            // strict compares keep the earliest hit on a tie
            if (seg_hits == 0) begin
                r2_least = r2;
                r2_most  = r2;
                inner_cx = i_conf_x;
                inner_cy = i_conf_y;
                outer_cx = i_conf_x;
                outer_cy = i_conf_y;
            end else begin
                if (r2 < r2_least) begin
                    r2_least = r2;
                    inner_cx = i_conf_x;
                    inner_cy = i_conf_y;
                end
                if (r2 > r2_most) begin
                    r2_most  = r2;
                    outer_cx = i_conf_x;
                    outer_cy = i_conf_y;
                end
            end
            if (i_wire_number < low_wire) begin
                low_wire       = i_wire_number;
                low_wire_layer = i_layer_wires;
            end
            if (i_wire_number > high_wire) high_wire = i_wire_number;
            radius_sum = radius_sum + TSS_SUM_W'(radius_floor(r2));
            z_sum      = z_sum + TSS_SUM_W'(i_wire_z);
            seg_hits++;
        end
        if (i_last_hit) begin
            summaries_due.insert(summaries_due.size(), close_segment());
            clear_segment();
        end
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            if (mismatch_count < 10)
                $display("%0t: summary field %s wrong: expected %0d, got %0d",
                         $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_summary();
        t_seg_summary want;
        if (summaries_due.size() == 0) begin
            if (mismatch_count < 10)
                $display("%0t: summary transfer with no summary due", $time);
            mismatch_count++;
        end else begin
            want = summaries_due.pop_front();
            compare_field("dir_x", want.dir_x, i_dir_x);
            compare_field("dir_y", want.dir_y, i_dir_y);
            compare_field("wire_span", want.span, i_wire_span);
            compare_field("mean_radius", want.mean_radius, i_mean_radius);
            compare_field("mean_z", want.mean_z, i_mean_z);
            compare_field("hits_used", want.hits, i_hits_used);
            compare_field("overflow", want.overflow, i_overflow);
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_segment();
            summaries_due.delete();
        end else begin
            if (i_sum_valid && i_sum_ready) check_summary();
            if (i_hit_valid && i_hit_ready) fold_hit();
        end
        due_count = summaries_due.size();
    end

endmodule

// ===== test/tb_track_segment_summary_unit.sv =====
// testbench top of the track segment summary unit: clock, reset, hit stimulus and verdict
module tb_track_segment_summary_unit;
    import tss_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    localparam int HOLD_CYCLES  = 600;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_HITS  = 600;

    typedef struct packed {
        logic signed [TSS_POS_W-1:0]  x;
        logic signed [TSS_POS_W-1:0]  y;
        logic signed [TSS_POS_W-1:0]  z;
        logic signed [TSS_CONF_W-1:0] cx;
        logic signed [TSS_CONF_W-1:0] cy;
        logic        [TSS_WIRE_W-1:0] wire_no;
        logic        [TSS_WIRE_W-1:0] layer;
        logic                         last;
    } t_hit;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic signed [TSS_POS_W-1:0]  i_wire_x;
    logic signed [TSS_POS_W-1:0]  i_wire_y;
    logic signed [TSS_POS_W-1:0]  i_wire_z;
    logic signed [TSS_CONF_W-1:0] i_conf_x;
    logic signed [TSS_CONF_W-1:0] i_conf_y;
    logic        [TSS_WIRE_W-1:0] i_wire_number;
    logic        [TSS_WIRE_W-1:0] i_layer_wires;
    logic                         i_last_hit;
    logic                         o_valid;
    logic                         i_ready;
    logic signed [TSS_DIR_W-1:0]  o_dir_x;
    logic signed [TSS_DIR_W-1:0]  o_dir_y;
    logic        [TSS_WIRE_W-1:0] o_wire_span;
    logic        [TSS_MEAN_W-1:0] o_mean_radius;
    logic signed [TSS_MEAN_W-1:0] o_mean_z;
    logic        [TSS_CNT_W-1:0]  o_hits_used;
    logic                         o_overflow;

    int mismatches;
    int summaries_due;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hits_sent         = 0;
    int segments_sent     = 0;
    int overflow_segments = 0;
    int seg_hits          = 0;
    int summaries_taken   = 0;
    int quiet_cycles      = 0;

    track_segment_summary_unit u_dut (.*);

    tss_summary_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_hit_valid     (i_valid),
        .i_hit_ready     (o_ready),
        .i_wire_x        (i_wire_x),
        .i_wire_y        (i_wire_y),
        .i_wire_z        (i_wire_z),
        .i_conf_x        (i_conf_x),
        .i_conf_y        (i_conf_y),
        .i_wire_number   (i_wire_number),
        .i_layer_wires   (i_layer_wires),
        .i_last_hit      (i_last_hit),
        .i_sum_valid     (o_valid),
        .i_sum_ready     (i_ready),
        .i_dir_x         (o_dir_x),
        .i_dir_y         (o_dir_y),
        .i_wire_span     (o_wire_span),
        .i_mean_radius   (o_mean_radius),
        .i_mean_z        (o_mean_z),
        .i_hits_used     (o_hits_used),
        .i_overflow      (o_overflow),
        .o_mismatches    (mismatches),
        .o_summaries_due (summaries_due)
    );

    // clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_hit mk_hit(input int x, input int y, input int z, input int cx,
                                    input int cy, input int wire_no, input int layer,
                                    input bit last);
        t_hit h;
        h.x       = TSS_POS_W'(x);
        h.y       = TSS_POS_W'(y);
        h.z       = TSS_POS_W'(z);
        h.cx      = TSS_CONF_W'(cx);
        h.cy      = TSS_CONF_W'(cy);
        h.wire_no = TSS_WIRE_W'(wire_no);
        h.layer   = TSS_WIRE_W'(layer);
        h.last    = last;
        return h;
    endfunction

    function automatic logic signed [TSS_POS_W-1:0] corner_pos();
        case ($urandom_range(0, 4))
            0:       return -16'sd32768;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    // random hit within a segment whose layer size is given
    function automatic t_hit rand_hit(input t_hit prev, input int layer, input bit last);
        t_hit h;
        int   pick;
        h.x  = TSS_POS_W'($urandom);
        h.y  = TSS_POS_W'($urandom);
        h.z  = TSS_POS_W'($urandom);
        h.cx = TSS_CONF_W'($urandom);
        h.cy = TSS_CONF_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            // same radius as the previous hit, swapped coordinates
            h.x = prev.y;
            h.y = prev.x;
        end else if (pick == 1) begin
            h.x = prev.x;
            h.y = prev.y;
        end else if (pick == 2) begin
            h.x = corner_pos();
            h.y = corner_pos();
            h.z = corner_pos();
        end else if (pick < 6) begin
            h.x = TSS_POS_W'(int'($urandom_range(0, 4000)) - 2000);
            h.y = TSS_POS_W'(int'($urandom_range(0, 4000)) - 2000);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            h.wire_no = prev.wire_no;
        else if (pick == 1)
            h.wire_no = TSS_WIRE_W'($urandom_range(1000, 1023));
        else if (layer >= 1 && layer <= 1000)
            h.wire_no = TSS_WIRE_W'($urandom_range(0, layer - 1));
        else
            h.wire_no = TSS_WIRE_W'($urandom);
        h.layer = ($urandom_range(0, 9) == 0) ? TSS_WIRE_W'($urandom) : TSS_WIRE_W'(layer);
        h.last  = last;
        return h;
    endfunction

    // one hit transfer, payload set at the falling edge
    task automatic send_hit(input t_hit h);
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_wire_x      <= h.x;
        i_wire_y      <= h.y;
        i_wire_z      <= h.z;
        i_conf_x      <= h.cx;
        i_conf_y      <= h.cy;
        i_wire_number <= h.wire_no;
        i_layer_wires <= h.layer;
        i_last_hit    <= h.last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        hits_sent++;
        seg_hits++;
        if (h.last) begin
            segments_sent++;
            if (seg_hits > MAX_HITS) overflow_segments++;
            seg_hits = 0;
        end
    endtask

    task automatic idle(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // sender waits until every predicted summary has come out
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (summaries_due == 0);
    endtask

    // summary receiver: random stalls, calm stretches, one long hold-off
    initial begin
        int gap;
        int phase_left;
        bit calm;
        gap        = 0;
        phase_left = 0;
        calm       = 1'b0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
                i_ready <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    calm       = ($urandom_range(0, 3) == 0);
                    phase_left = $urandom_range(50, 300);
                end
                phase_left--;
                if (gap == 0 && !calm) gap = pick_gap();
                if (gap > 0) begin
                    gap--;
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (o_valid && i_ready && i_rst_n) summaries_taken++;
        if (i_rst_n && ((i_valid && o_ready) || (o_valid && i_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles, giving up", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_hit prev;
        int   seg_len;
        int   layer;
        int   r;
        int   seg_idx;
        int   random_start;
        bit   sender_calm;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_wire_x      = '0;
        i_wire_y      = '0;
        i_wire_z      = '0;
        i_conf_x      = '0;
        i_conf_y      = '0;
        i_wire_number = '0;
        i_layer_wires = '0;
        i_last_hit    = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-hit segments at the field extremes, largest radius first
        send_hit(mk_hit(-32768, -32768, -32768, -8388608, 8388607, 999, 1000, 1));
        idle(pick_gap());
        send_hit(mk_hit(32767, 0, 32767, 8388607, -8388608, 0, 1, 1));
        send_hit(mk_hit(0, 32767, -1, -1, 1, 1023, 1023, 1));
        send_hit(mk_hit(0, 0, 0, 0, 0, 0, 1, 1));
        idle(pick_gap());
        // wires at and above 1000 in an empty layer: fold saturates at zero
        send_hit(mk_hit(0, 0, 0, 0, 0, 1000, 0, 0));
        send_hit(mk_hit(5, 5, 5, 100, 100, 1023, 0, 1));
        // ties in radius and in wire keep the earliest hit, span folds over half
        send_hit(mk_hit(300, 400, 10, 1000, 2000, 5, 1000, 0));
        send_hit(mk_hit(400, 300, -20, 3000, 4000, 5, 800, 0));
        idle(pick_gap());
        send_hit(mk_hit(0, 500, 30, 5000, 6000, 900, 1000, 0));
        send_hit(mk_hit(100, 0, -40, 7000, 8000, 3, 1000, 0));
        send_hit(mk_hit(-100, 0, 50, 9000, 10000, 3, 500, 1));
        // mean z truncates toward zero
        send_hit(mk_hit(-7, 0, -7, 11, 12, 10, 100, 0));
        send_hit(mk_hit(0, -8, -8, 13, 14, 11, 100, 0));
        send_hit(mk_hit(-9, 9, -8, 15, 16, 12, 100, 1));
        // span exactly half the layer, then one past half
        send_hit(mk_hit(1, 1, 1, 0, 0, 10, 100, 0));
        send_hit(mk_hit(2, 2, 2, 0, 0, 60, 100, 1));
        send_hit(mk_hit(1, 1, 1, 0, 0, 10, 100, 0));
        send_hit(mk_hit(2, 2, 2, 0, 0, 61, 100, 1));
        drain();

        // receiver holds off while hits keep coming, so the output backs up
        hold_req = 1'b1;
        prev = mk_hit(0, 0, 0, 0, 0, 0, 1, 1);
        repeat (4) begin
            prev = rand_hit(prev, 500, 1'b1);
            send_hit(prev);
        end
        drain();

        // random segments, mostly short, a few running past the hit limit
        random_start = hits_sent;
        seg_idx      = 0;
        while (hits_sent - random_start < RANDOM_HITS) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (seg_idx == 0)
                seg_len = MAX_HITS + 3;
            else if (r < 60)
                seg_len = $urandom_range(1, 4);
            else if (r < 93)
                seg_len = $urandom_range(5, 20);
            else
                seg_len = $urandom_range(MAX_HITS - 1, MAX_HITS + 6);
            r = $urandom_range(0, 19);
            if (r == 0)
                layer = 0;
            else if (r == 1)
                layer = $urandom_range(1001, 1023);
            else
                layer = $urandom_range(1, 1000);
            for (int k = 0; k < seg_len; k++) begin
                prev = rand_hit(prev, layer, k == seg_len - 1);
                send_hit(prev);
                idle(sender_calm ? 0 : pick_gap());
            end
            if (seg_idx == 20) drain();
            seg_idx++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d hits in %0d segments, %0d of them past the %0d-hit limit",
                 hits_sent, segments_sent, overflow_segments, MAX_HITS);
        $display("%0d summaries taken, one %0d-cycle receiver hold-off, %0d mismatches",
                 summaries_taken, HOLD_CYCLES, mismatches);
        if (mismatches == 0 && summaries_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== track_segment_summary_unit.f =====
src/tss_pkg.sv
src/tss_serial_unit.sv
src/track_segment_summary_unit.sv
test/tss_summary_checker.sv
test/tb_track_segment_summary_unit.sv
